// ----- rtl/bsf_pkg.sv -----
// Shared constants, codes and types for the byte substring finder.
// No dependencies; the core, bsf_cfg, bsf_match and the testbench refer to this package.
`timescale 1ns / 1ps
`default_nettype none

package bsf_pkg;

    localparam int PAT_BYTES       = 16;
    localparam int PAT_IDX_W       = 4;
    localparam int LEN_W           = 5;
    localparam int LIMIT_W         = 16;
    localparam int COUNT_W         = 17;
    localparam int OFFSET_OUT_W    = 32;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 2;
    localparam int MAX_PATTERN_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LO    = 2'd0,
        CFG_PAT_HI    = 2'd1,
        CFG_PAT_LEN   = 2'd2,
        CFG_RES_LIMIT = 2'd3
    } t_cfg_reg;

    // Configuration as seen by the datapath: length already clipped,
    // limit already raised to at least one.
    typedef struct packed {
        logic [PAT_BYTES-1:0][7:0] pattern;
        logic [LEN_W-1:0]          length;
        logic [LIMIT_W-1:0]        limit;
    } t_cfg;

endpackage

`default_nettype wire

// ----- rtl/bsf_in_if.sv -----
// Input channel of the byte substring finder: one buffer byte per item.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface bsf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

`default_nettype wire

// ----- rtl/bsf_out_if.sv -----
// Output channel of the byte substring finder: one match report per item.
// Standalone; field widths are fixed by the block's result format.
`timescale 1ns / 1ps
`default_nettype none

interface bsf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] match_offset;
    logic [16:0] match_index;
    logic        limit_reached;

    modport source (output valid, output match_offset, output match_index,
                    output limit_reached, input ready);
    modport sink   (input valid, input match_offset, input match_index,
                    input limit_reached, output ready);
endinterface

`default_nettype wire

// ----- rtl/byte_substring_finder_core.sv -----
// Top level of the byte substring finder: input stage, match tracking, result register.
// Depends on bsf_pkg, bsf_in_if, bsf_out_if, bsf_cfg and bsf_match.
//
// Usage:
//   Stream a buffer one byte per item on i_in (valid/ready); set end_of_buffer on
//   the last byte. Every exact occurrence of the configured pattern up to the limit, overlapping
//   ones too, yields one item on o_out carrying the start offset, the running
//   match count for the buffer and a flag telling whether this match hit the limit.
//   Program the pattern, length and limit through the write port (i_cfg_we,
//   i_cfg_idx, i_cfg_data) only while no item is in flight.
// Timing:
//   An item is taken into the input register, then compared and scored against the
//   window once the result slot is free or draining, and a match is loaded into the
//   output register as the item leaves the input register. One item per cycle is
//   sustained while results are taken: the whole compare is one rank of byte
//   comparators feeding an AND, plus one counter and one compare.
// Stall:
//   When o_out holds a result that is not taken, the input register takes at most
//   one more item, then ready drops until the result drains.
// Reset:
//   Synchronous, active low. Clears both channel stages, position, match count and
//   stop flag; pattern length returns to zero (no matching) and limit to 65535.
`timescale 1ns / 1ps
`default_nettype none

module byte_substring_finder_core #(
    parameter int MAX_PATTERN = bsf_pkg::MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = bsf_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [bsf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [bsf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    bsf_in_if.sink                                i_in,
    bsf_out_if.source                             o_out
);

    localparam logic [OFFSET_BITS-1:0] POS_TOP = '1;

    bsf_pkg::t_cfg cfg;

    // Input stage
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eob;

    // Per-buffer tracking
    logic [OFFSET_BITS-1:0]      r_pos;
    logic [bsf_pkg::COUNT_W-1:0] r_count;
    logic                        r_stopped;

    // Result register
    logic                             r_out_valid;
    logic [bsf_pkg::OFFSET_OUT_W-1:0] r_out_off;
    logic [bsf_pkg::COUNT_W-1:0]      r_out_idx;
    logic                             r_out_hit;

    logic                             advance;
    logic                             process;
    logic                             match;
    logic                             found;
    logic                             hit;
    logic [OFFSET_BITS-1:0]           len_m1;
    logic [OFFSET_BITS-1:0]           off_full;
    logic [bsf_pkg::OFFSET_OUT_W-1:0] off_out;
    logic [bsf_pkg::COUNT_W-1:0]      n_count;
    logic [OFFSET_BITS-1:0]           n_pos;

    bsf_cfg #(.MAX_PATTERN(MAX_PATTERN)) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bsf_match #(.MAX_PATTERN(MAX_PATTERN)) u_match (
        .i_clk   (i_clk),
        .i_shift (process),
        .i_byte  (r_in_byte),
        .i_cfg   (cfg),
        .o_match (match)
    );

    // Result slot is free or draining this cycle: the held item may move on.
    assign advance    = !r_out_valid || o_out.ready;
    assign process    = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    // A match counts only with enough bytes of this buffer seen, search live,
    // and position not yet saturated.
    assign len_m1   = OFFSET_BITS'(cfg.length) - OFFSET_BITS'(1);
    assign found    = process && match && !r_stopped && (r_pos != POS_TOP)
                   && (r_pos >= len_m1);
    assign n_count  = r_count + bsf_pkg::COUNT_W'(1);
    assign hit      = n_count >= bsf_pkg::COUNT_W'(cfg.limit);
    assign off_full = r_pos - len_m1;
    assign n_pos    = (r_pos != POS_TOP) ? (r_pos + OFFSET_BITS'(1)) : r_pos;

    if (OFFSET_BITS >= bsf_pkg::OFFSET_OUT_W) begin : g_off_trunc
        assign off_out = off_full[bsf_pkg::OFFSET_OUT_W-1:0];
    end else begin : g_off_ext
        assign off_out = bsf_pkg::OFFSET_OUT_W'(off_full);
    end

    // Input register: load on accept, drop once handed to the compare.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_eob  <= i_in.end_of_buffer;
        end
    end

    // Advance position and count; end of buffer clears them after this byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_count   <= '0;
            r_stopped <= 1'b0;
        end else if (process) begin
            if (r_in_eob) begin
                r_pos     <= '0;
                r_count   <= '0;
                r_stopped <= 1'b0;
            end else begin
                r_pos <= n_pos;
                if (found) begin
                    r_count <= n_count;
                    if (hit) begin
                        r_stopped <= 1'b1;
                    end
                end
            end
        end
    end

    // Result register: refill or empty whenever the slot is free or taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (found) begin
            r_out_off <= off_out;
            r_out_idx <= n_count;
            r_out_hit <= hit;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.match_offset  = r_out_off;
    assign o_out.match_index   = r_out_idx;
    assign o_out.limit_reached = r_out_hit;

    // A reported match always carries a nonzero running count.
    a_idx_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_idx != '0))
        else $error("match reported with zero index");

    // Reaching the limit mid-buffer must stop the search.
    a_stop_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (found && hit && !r_in_eob) |=> r_stopped)
        else $error("search not stopped after limit reached");

    // Input backpressure only when both stages hold an item.
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_in_valid && r_out_valid))
        else $error("input stalled with a free stage");

endmodule

`default_nettype wire

// ----- rtl/bsf_cfg.sv -----
// Configuration registers of the byte substring finder.
// Depends on bsf_pkg for register codes, widths and the t_cfg struct.
`timescale 1ns / 1ps
`default_nettype none

module bsf_cfg #(
    parameter int MAX_PATTERN = bsf_pkg::MAX_PATTERN_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [bsf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [bsf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output bsf_pkg::t_cfg                         o_cfg
);

    localparam int EFF_MAX = (MAX_PATTERN < bsf_pkg::PAT_BYTES) ? MAX_PATTERN
                                                                : bsf_pkg::PAT_BYTES;
    localparam logic [bsf_pkg::LEN_W-1:0] LEN_CAP = bsf_pkg::LEN_W'(EFF_MAX);

    logic [63:0]                  r_pat_lo;
    logic [63:0]                  r_pat_hi;
    logic [bsf_pkg::LEN_W-1:0]    r_len;
    logic [bsf_pkg::LIMIT_W-1:0]  r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_len    <= '0;
            r_limit  <= bsf_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (bsf_pkg::t_cfg_reg'(i_cfg_idx))
                bsf_pkg::CFG_PAT_LO:    r_pat_lo <= i_cfg_data[63:0];
                bsf_pkg::CFG_PAT_HI:    r_pat_hi <= i_cfg_data[63:0];
                bsf_pkg::CFG_PAT_LEN:   r_len    <= i_cfg_data[bsf_pkg::LEN_W-1:0];
                bsf_pkg::CFG_RES_LIMIT: r_limit  <= i_cfg_data[bsf_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clip length to the window; a zero limit behaves as one.
    always_comb begin
        o_cfg.pattern = {r_pat_hi, r_pat_lo};
        o_cfg.length  = (r_len > LEN_CAP) ? LEN_CAP : r_len;
        o_cfg.limit   = (r_limit == '0) ? bsf_pkg::LIMIT_W'(1) : r_limit;
    end

endmodule

`default_nettype wire

// ----- rtl/bsf_match.sv -----
// Byte window and parallel pattern compare of the byte substring finder.
// Depends on bsf_pkg for widths and the t_cfg struct.
`timescale 1ns / 1ps
`default_nettype none

module bsf_match #(
    parameter int MAX_PATTERN = bsf_pkg::MAX_PATTERN_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_shift,
    input  wire logic [7:0]    i_byte,
    input  wire bsf_pkg::t_cfg i_cfg,
    output logic               o_match
);

    localparam int WIN = (MAX_PATTERN < bsf_pkg::PAT_BYTES) ? MAX_PATTERN
                                                            : bsf_pkg::PAT_BYTES;

    logic [7:0]   r_window [WIN];
    logic [7:0]   nw       [WIN];
    logic [WIN-1:0] ok;

    // Window as it stands with the new byte in front, newest first.
    always_comb begin
        nw[0] = i_byte;
        for (int j = 1; j < WIN; j++) begin
            nw[j] = r_window[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            for (int j = 0; j < WIN; j++) begin
                r_window[j] <= nw[j];
            end
        end
    end

    // Window slot j must equal pattern byte (length-1-j) for all slots in use.
    for (genvar j = 0; j < WIN; j++) begin : g_cmp
        logic [bsf_pkg::LEN_W-1:0] pidx;
        assign pidx  = i_cfg.length - bsf_pkg::LEN_W'(j + 1);
        assign ok[j] = (bsf_pkg::LEN_W'(j) >= i_cfg.length)
                    || (nw[j] == i_cfg.pattern[pidx[bsf_pkg::PAT_IDX_W-1:0]]);
    end

    assign o_match = (i_cfg.length != '0) && (&ok);

endmodule

`default_nettype wire

// ----- tb/tb_byte_substring_finder_core.sv -----
// Self-checking testbench for byte_substring_finder_core: streams buffers byte by byte
// and checks every match report against a cycle-free predictor held in this module.
// Depends on bsf_pkg, bsf_in_if, bsf_out_if and the core itself.
`timescale 1ns / 1ps

module tb_byte_substring_finder_core;

    // Generous bound on the whole run.
    localparam int CYCLE_LIMIT = 200000;
    // Extra wait after the last report, to let the pipe empty.
    localparam int SETTLE_CYCLES = 6;
    localparam logic [31:0] POS_TOP = '1;

    typedef struct packed {
        logic [31:0] offset;
        logic [16:0] index;
        logic        at_limit;
    } t_match;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                           cfg_we;
    bsf_pkg::t_cfg_reg              cfg_idx;
    logic [bsf_pkg::CFG_DATA_W-1:0] cfg_data;

    bsf_in_if  in_ch ();
    bsf_out_if out_ch ();

    byte_substring_finder_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow of the block: configuration as written, search state as it should be.
    logic [63:0]  pattern_lo;
    logic [63:0]  pattern_hi;
    logic [4:0]   pattern_len;
    logic [15:0]  match_limit;
    logic [7:0]   win_bytes [bsf_pkg::PAT_BYTES];
    logic [31:0]  byte_pos;
    logic [16:0]  match_count;
    logic         scan_stopped;

    t_match expected_matches [$];
    int     mismatches = 0;
    int     cycle_count = 0;

    // Idling knobs, in percent of cycles.
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    // Long receiver hold-off, counted down by the ready process.
    int hold_left = 0;

    // Advance the shadow search by one byte; return 1 with the report when it matches.
    function automatic bit scan_byte(input logic [7:0] d, input logic eob, output t_match m);
        logic [127:0] pat;
        logic [16:0]  lim;
        int           eff;
        bit           same;
        bit           found;
        found = 1'b0;
        m = '0;
        pat = {pattern_hi, pattern_lo};
        // Clip oversized lengths to the window size.
        eff = (pattern_len > bsf_pkg::PAT_BYTES) ? bsf_pkg::PAT_BYTES : int'(pattern_len);
        for (int k = bsf_pkg::PAT_BYTES - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
        win_bytes[0] = d;
        // Compare only once enough bytes of this buffer are in, and never at a saturated
        // position or after the limit stopped the search.
        if (eff > 0 && !scan_stopped && byte_pos != POS_TOP &&
            ({1'b0, byte_pos} + 33'd1) >= 33'(eff)) begin
            same = 1'b1;
            for (int k = 0; k < eff; k++) begin
                if (win_bytes[eff-1-k] != pat[8*k +: 8]) same = 1'b0;
            end
            if (same) begin
                // A zero limit behaves as a limit of one.
                lim = (match_limit == '0) ? 17'd1 : {1'b0, match_limit};
                match_count = match_count + 17'd1;
                m.offset = byte_pos + 32'd1 - 32'(eff);
                m.index = match_count;
                m.at_limit = (match_count >= lim);
                if (m.at_limit) scan_stopped = 1'b1;
                found = 1'b1;
            end
        end
        if (byte_pos != POS_TOP) byte_pos = byte_pos + 32'd1;
        // Close the buffer: position, count and stop clear, the window stays.
        if (eob) begin
            byte_pos = '0;
            match_count = '0;
            scan_stopped = 1'b0;
        end
        return found;
    endfunction

    // Offer one byte, hold it until taken, then record what it should produce.
    task automatic send_byte(input logic [7:0] d, input logic eob);
        t_match m;
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= d;
        in_ch.end_of_buffer <= eob;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (scan_byte(d, eob, m)) expected_matches.insert(expected_matches.size(), m);
    endtask

    // Stop offering and wait for every outstanding report, then let the pipe settle.
    task automatic wait_all_matches();
        in_ch.valid <= 1'b0;
        while (expected_matches.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all four registers on consecutive edges; only call while the block is idle.
    // Upper bits of the narrow registers carry junk that the block must drop.
    task automatic program_search(input logic [63:0] lo, input logic [63:0] hi,
                                  input logic [4:0] len, input logic [15:0] lim);
        cfg_we <= 1'b1;
        cfg_idx <= bsf_pkg::CFG_PAT_LO;
        cfg_data <= lo;
        @(posedge i_clk);
        cfg_idx <= bsf_pkg::CFG_PAT_HI;
        cfg_data <= hi;
        @(posedge i_clk);
        cfg_idx <= bsf_pkg::CFG_PAT_LEN;
        cfg_data <= {{27{1'b0}}, $urandom, len};
        @(posedge i_clk);
        cfg_idx <= bsf_pkg::CFG_RES_LIMIT;
        cfg_data <= {{16{1'b0}}, $urandom, lim};
        @(posedge i_clk);
        cfg_we <= 1'b0;
        pattern_lo = lo;
        pattern_hi = hi;
        pattern_len = len;
        match_limit = lim;
    endtask

    // Reset configuration has length zero: nothing may ever match.
    task automatic test_zero_length();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        wait_all_matches();
    endtask

    // A lone byte ends a buffer, so the next buffer's first byte must not complete a
    // match with it; then overlapping matches, the last one on the closing byte.
    task automatic test_prefix_and_overlap();
        program_search(64'h6161, 64'h0, 5'd2, 16'hFFFF);
        send_byte(8'h61, 1'b1);
        send_byte(8'h61, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h61, 1'b1);
        wait_all_matches();
    endtask

    // Zero limit lets exactly one match through; the buffer end re-arms the search.
    task automatic test_limit_zero();
        program_search(64'hFF, 64'h0, 5'd1, 16'h0000);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b1);
        wait_all_matches();
    endtask

    // Largest length code clips to sixteen; pattern registers at both extremes.
    task automatic test_oversized_length();
        program_search(64'h0, '1, 5'd31, 16'hFFFF);
        for (int k = 0; k < bsf_pkg::PAT_BYTES; k++) begin
            send_byte((k < 8) ? 8'h00 : 8'hFF, k == bsf_pkg::PAT_BYTES - 1);
        end
        wait_all_matches();
    endtask

    // Hold the receiver off for a long stretch while every byte matches, so the
    // block fills and drops its input ready.
    task automatic test_backpressure();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        program_search(64'h5A, 64'h0, 5'd1, 16'hFFFF);
        hold_left <= 300;
        for (int k = 0; k < 40; k++) send_byte(8'h5A, k == 39);
        wait_all_matches();
    endtask

    // Random configurations, each followed by buffers built mostly from the pattern
    // so that matches, overlaps and the limit come up often.
    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input int n_configs, input int items_per_config);
        logic [7:0]  pat [bsf_pkg::PAT_BYTES];
        logic [7:0]  chunk [$];
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  len;
        logic [15:0] lim;
        int          eff;
        int          sent;
        int          blen;
        int          r;
        bit          two_letters;
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        for (int c = 0; c < n_configs; c++) begin
            r = $urandom_range(0, 9);
            if (r == 0) len = 5'd0;
            else if (r == 1) len = 5'($urandom_range(17, 31));
            else if (r == 9) len = 5'($urandom_range(7, 16));
            else len = 5'($urandom_range(1, 6));
            // A two-letter alphabet makes self-overlapping patterns likely.
            two_letters = ($urandom_range(0, 2) == 0);
            for (int k = 0; k < bsf_pkg::PAT_BYTES; k++) begin
                pat[k] = two_letters ? 8'($urandom_range(8'h41, 8'h42))
                                     : 8'($urandom_range(0, 255));
                if (k < 8) lo[8*k +: 8] = pat[k];
                else hi[8*(k-8) +: 8] = pat[k];
            end
            case ($urandom_range(0, 5))
                0: lim = 16'd0;
                1: lim = 16'd1;
                2: lim = 16'($urandom_range(2, 4));
                3: lim = 16'hFFFF;
                4: lim = 16'($urandom_range(0, 65535));
                default: lim = 16'($urandom_range(5, 20));
            endcase
            program_search(lo, hi, len, lim);
            eff = (len > bsf_pkg::PAT_BYTES) ? bsf_pkg::PAT_BYTES : int'(len);
            sent = 0;
            while (sent < items_per_config) begin
                chunk.delete();
                blen = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
                                                   : $urandom_range(4, 40);
                while (chunk.size() < blen) begin
                    r = $urandom_range(0, 99);
                    if (r < 25 && eff > 0) begin
                        for (int k = 0; k < eff; k++) chunk.insert(chunk.size(), pat[k]);
                    end else if (r < 80) begin
                        chunk.insert(chunk.size(),
                                     pat[$urandom_range(0, (eff > 0) ? eff - 1 : 3)]);
                    end else begin
                        chunk.insert(chunk.size(), 8'($urandom_range(0, 255)));
                    end
                end
                foreach (chunk[k]) send_byte(chunk[k], k == chunk.size() - 1);
                sent += chunk.size();
            end
            wait_all_matches();
        end
    endtask

    // Receiver: random stalls per the current phase, plus the long hold-off on request.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left <= hold_left - 1;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    // Compare each taken report with the oldest outstanding one.
    always @(posedge i_clk) begin : check_matches
        t_match want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_matches.size() == 0) begin
                $display("%0t extra report: expected none, actual offset %0d index %0d limit %0b",
                         $time, out_ch.match_offset, out_ch.match_index, out_ch.limit_reached);
                mismatches++;
            end else begin
                want = expected_matches.pop_front();
                if (out_ch.match_offset !== want.offset) begin
                    $display("%0t match_offset: expected %0d actual %0d",
                             $time, want.offset, out_ch.match_offset);
                    mismatches++;
                end
                if (out_ch.match_index !== want.index) begin
                    $display("%0t match_index: expected %0d actual %0d",
                             $time, want.index, out_ch.match_index);
                    mismatches++;
                end
                if (out_ch.limit_reached !== want.at_limit) begin
                    $display("%0t limit_reached: expected %0b actual %0b",
                             $time, want.at_limit, out_ch.limit_reached);
                    mismatches++;
                end
            end
        end
    end

    // Drop the run if it hangs, e.g. on a report that never comes.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[byte_substring_finder_core] ERROR");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = bsf_pkg::CFG_PAT_LO;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = 8'h00;
        in_ch.end_of_buffer = 1'b0;
        // Shadow starts at the reset state of the block.
        pattern_lo = '0;
        pattern_hi = '0;
        pattern_len = '0;
        match_limit = bsf_pkg::LIMIT_RESET;
        foreach (win_bytes[k]) win_bytes[k] = 8'h00;
        byte_pos = '0;
        match_count = '0;
        scan_stopped = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_length();
        test_prefix_and_overlap();
        test_limit_zero();
        test_oversized_length();
        test_backpressure();
        // Idling phases: none, sender only, receiver only, both.
        test_random_traffic(0, 0, 5, 56);
        test_random_traffic(52, 0, 5, 56);
        test_random_traffic(0, 52, 5, 56);
        test_random_traffic(18, 18, 5, 56);

        wait_all_matches();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[byte_substring_finder_core] OK");
        end else begin
            $display("[byte_substring_finder_core] ERROR");
        end
        $finish;
    end

endmodule

// ----- byte_substring_finder_core.f -----
rtl/bsf_pkg.sv
rtl/bsf_in_if.sv
rtl/bsf_out_if.sv
rtl/bsf_cfg.sv
rtl/bsf_match.sv
rtl/byte_substring_finder_core.sv
tb/tb_byte_substring_finder_core.sv
